FILE: sv/fbpa_pkg.sv
// shared types and codes for the fixed block pool allocator
`default_nettype none

package fbpa_pkg;

    // width of block counts and of the count-like config registers
    localparam int CNT_W = 9;
    // width of a block index on the stream ports
    localparam int BIDX_W = 8;

    // configuration register indexes
    localparam logic [1:0] CFG_POOL_BLOCKS  = 2'd0;
    localparam logic [1:0] CFG_LAZY_MODE    = 2'd1;
    localparam logic [1:0] CFG_REFILL_BATCH = 2'd2;

    // command codes
    localparam logic [1:0] CMD_ALLOC   = 2'd0;
    localparam logic [1:0] CMD_FREE    = 2'd1;
    localparam logic [1:0] CMD_REBUILD = 2'd2;
    // unassigned command, answered with ok and no change
    localparam logic [1:0] CMD_RSVD    = 2'd3;

    // status codes
    localparam logic [1:0] ST_OK    = 2'd0;
    localparam logic [1:0] ST_EMPTY = 2'd1;
    localparam logic [1:0] ST_ZERO  = 2'd2;
    localparam logic [1:0] ST_RANGE = 2'd3;

    // configuration seen by the controller
    typedef struct packed {
        logic [CNT_W-1:0] block_cnt;
        logic             lazy;
        logic [CNT_W-1:0] batch;
    } t_cfg;

endpackage

`default_nettype wire

FILE: sv/fixed_block_pool_allocator.sv
// top level of the fixed block pool allocator: config registers, controller, link memory
// allocate, free and unknown commands reach the output register through the pop or response state
// rebuild writes one link per block through the memory port in the fill state
// an allocate that triggers a lazy refill pushes the refilled blocks in the fill state and grants the last one
// requests are taken only in the idle state; the next one is taken while the previous result waits
// reset: synchronous, active low; list empty, bump pointer zero, link memory not cleared
`default_nettype none

module fixed_block_pool_allocator
    import fbpa_pkg::*;
#(
    parameter int NUM_BLOCKS = 256
) (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    // configuration writes
    input  wire logic        i_cfg_we,
    input  wire logic [1:0]  i_cfg_idx,
    input  wire logic [8:0]  i_cfg_data,
    // requests
    input  wire logic        s_axis_tvalid,
    output logic             s_axis_tready,
    input  wire logic [23:0] s_axis_tdata,   // request_size[15:0], block_index[23:16]
    input  wire logic [1:0]  s_axis_tuser,   // cmd[1:0]
    // results
    output logic             m_axis_tvalid,
    input  wire logic        m_axis_tready,
    output logic [15:0]      m_axis_tdata    // status[1:0], granted_block[9:2], zero[15:10]
);

    localparam int IDX_W = $clog2(NUM_BLOCKS);
    localparam int CAP   = (NUM_BLOCKS < 256) ? NUM_BLOCKS : 256;

    logic [CNT_W-1:0]  r_pool_blocks;
    logic              r_lazy_mode;
    logic [CNT_W-1:0]  r_refill_batch;
    t_cfg              cfg;

    logic              mem_we;
    logic [IDX_W-1:0]  mem_waddr;
    logic [IDX_W:0]    mem_wdata;
    logic              mem_re;
    logic [IDX_W-1:0]  mem_raddr;
    logic [IDX_W:0]    mem_rdata;
    logic [1:0]        status;
    logic [BIDX_W-1:0] grant;

    // configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pool_blocks  <= CNT_W'(256);
            r_lazy_mode    <= 1'b0;
            r_refill_batch <= CNT_W'(16);
        end else if (i_cfg_we) begin
            unique case (i_cfg_idx)
                CFG_POOL_BLOCKS:  r_pool_blocks  <= i_cfg_data;
                CFG_LAZY_MODE:    r_lazy_mode    <= i_cfg_data[0];
                CFG_REFILL_BATCH: r_refill_batch <= i_cfg_data;
                default: begin
                end
            endcase
        end
    end

    // effective block count is capped by the memory depth
    always_comb begin
        cfg.block_cnt = (r_pool_blocks > CNT_W'(CAP)) ? CNT_W'(CAP) : r_pool_blocks;
        cfg.lazy      = r_lazy_mode;
        cfg.batch     = r_refill_batch;
    end

    fbpa_ctrl #(
        .IDX_W (IDX_W)
    ) u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg       (cfg),
        .i_in_valid  (s_axis_tvalid),
        .o_in_ready  (s_axis_tready),
        .i_cmd       (s_axis_tuser),
        .i_size_nz   (|s_axis_tdata[15:0]),
        .i_idx       (s_axis_tdata[23:16]),
        .o_out_valid (m_axis_tvalid),
        .i_out_ready (m_axis_tready),
        .o_status    (status),
        .o_grant     (grant),
        .o_mem_we    (mem_we),
        .o_mem_waddr (mem_waddr),
        .o_mem_wdata (mem_wdata),
        .o_mem_re    (mem_re),
        .o_mem_raddr (mem_raddr),
        .i_mem_rdata (mem_rdata)
    );

    fbpa_link_mem #(
        .DEPTH (NUM_BLOCKS),
        .WIDTH (IDX_W + 1)
    ) u_link_mem (
        .i_clk   (i_clk),
        .i_we    (mem_we),
        .i_waddr (mem_waddr),
        .i_wdata (mem_wdata),
        .i_re    (mem_re),
        .i_raddr (mem_raddr),
        .o_rdata (mem_rdata)
    );

    // result packing
    assign m_axis_tdata = {6'b0, grant, status};

endmodule

`default_nettype wire

FILE: sv/fbpa_link_mem.sv
// next-link memory: one write port, one read port with registered data
`default_nettype none

module fbpa_link_mem #(
    parameter int DEPTH = 256,
    parameter int WIDTH = 9
) (
    input  wire logic                     i_clk,
    input  wire logic                     i_we,
    input  wire logic [$clog2(DEPTH)-1:0] i_waddr,
    input  wire logic [WIDTH-1:0]         i_wdata,
    input  wire logic                     i_re,
    input  wire logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic      [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];

    // write port
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
    end

    // read port, registered data
    always_ff @(posedge i_clk) begin
        if (i_re) begin
            o_rdata <= r_mem[i_raddr];
        end
    end

endmodule

`default_nettype wire

FILE: sv/fbpa_ctrl.sv
// free list controller: head and bump registers, fill sequencer, result register
`default_nettype none

module fbpa_ctrl
    import fbpa_pkg::*;
#(
    parameter int IDX_W = 8
) (
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire t_cfg              i_cfg,
    // request side
    input  wire logic              i_in_valid,
    output logic                   o_in_ready,
    input  wire logic [1:0]        i_cmd,
    input  wire logic              i_size_nz,
    input  wire logic [BIDX_W-1:0] i_idx,
    // result side
    output logic                   o_out_valid,
    input  wire logic              i_out_ready,
    output logic [1:0]             o_status,
    output logic [BIDX_W-1:0]      o_grant,
    // link memory
    output logic                   o_mem_we,
    output logic [IDX_W-1:0]       o_mem_waddr,
    output logic [IDX_W:0]         o_mem_wdata,
    output logic                   o_mem_re,
    output logic [IDX_W-1:0]       o_mem_raddr,
    input  wire logic [IDX_W:0]    i_mem_rdata
);

    typedef enum logic [3:0] {
        S_IDLE = 4'b0001,
        S_FILL = 4'b0010,
        S_POP  = 4'b0100,
        S_RESP = 4'b1000
    } t_state;

    t_state            r_state, n_state;
    logic [IDX_W-1:0]  r_head, n_head;
    logic              r_hv, n_hv;
    logic [CNT_W-1:0]  r_bump, n_bump;
    logic [CNT_W-1:0]  r_fill, n_fill;
    logic [CNT_W-1:0]  r_last, n_last;
    logic              r_refill, n_refill;
    logic [1:0]        r_rstat, n_rstat;
    logic [BIDX_W-1:0] r_rgrant, n_rgrant;
    logic              r_ovalid, n_ovalid;
    logic [1:0]        r_ostat, n_ostat;
    logic [BIDX_W-1:0] r_ogrant, n_ogrant;

    logic              out_free;
    logic [CNT_W-1:0]  left;
    logic [CNT_W-1:0]  amount;

    // output slot can take a result this cycle
    assign out_free = !r_ovalid || i_out_ready;

    // size of a lazy refill
    assign left   = (r_bump < i_cfg.block_cnt) ? (i_cfg.block_cnt - r_bump) : '0;
    assign amount = (left < i_cfg.batch) ? left : i_cfg.batch;

    assign o_in_ready  = (r_state == S_IDLE);
    assign o_out_valid = r_ovalid;
    assign o_status    = r_ostat;
    assign o_grant     = r_ogrant;

    // next state and datapath
    always_comb begin
        n_state     = r_state;
        n_head      = r_head;
        n_hv        = r_hv;
        n_bump      = r_bump;
        n_fill      = r_fill;
        n_last      = r_last;
        n_refill    = r_refill;
        n_rstat     = r_rstat;
        n_rgrant    = r_rgrant;
        n_ovalid    = r_ovalid && !i_out_ready;
        n_ostat     = r_ostat;
        n_ogrant    = r_ogrant;
        o_mem_we    = 1'b0;
        o_mem_waddr = r_head;
        o_mem_wdata = {r_hv, r_head};
        o_mem_re    = 1'b0;
        o_mem_raddr = r_head;

        unique case (r_state)
            S_IDLE: begin
                if (i_in_valid) begin
                    n_rstat  = ST_OK;
                    n_rgrant = '0;
                    n_state  = S_RESP;
                    unique case (i_cmd)
                        CMD_ALLOC: begin
                            if (!i_size_nz) begin
                                n_rstat = ST_ZERO;
                            end else if (r_hv) begin
                                // pop: fetch the link of the head block
                                o_mem_re = 1'b1;
                                n_rgrant = BIDX_W'(r_head);
                                n_state  = S_POP;
                            end else if (i_cfg.lazy && amount != '0) begin
                                n_fill   = r_bump;
                                n_last   = r_bump + amount - CNT_W'(1);
                                n_bump   = r_bump + amount;
                                n_refill = 1'b1;
                                n_state  = S_FILL;
                            end else begin
                                n_rstat = ST_EMPTY;
                            end
                        end
                        CMD_FREE: begin
                            if ({1'b0, i_idx} >= i_cfg.block_cnt) begin
                                n_rstat = ST_RANGE;
                            end else begin
                                // push the freed block
                                o_mem_we    = 1'b1;
                                o_mem_waddr = IDX_W'(i_idx);
                                n_head      = IDX_W'(i_idx);
                                n_hv        = 1'b1;
                            end
                        end
                        CMD_REBUILD: begin
                            n_hv   = 1'b0;
                            n_bump = i_cfg.block_cnt;
                            if (i_cfg.block_cnt != '0) begin
                                n_fill   = '0;
                                n_last   = i_cfg.block_cnt - CNT_W'(1);
                                n_refill = 1'b0;
                                n_state  = S_FILL;
                            end
                        end
                        default: begin
                        end
                    endcase
                end
            end
            S_FILL: begin
                if (r_refill && r_fill == r_last) begin
                    // last refilled block is granted at once, list head untouched
                    n_rgrant = BIDX_W'(r_fill);
                    n_state  = S_RESP;
                end else begin
                    o_mem_we    = 1'b1;
                    o_mem_waddr = IDX_W'(r_fill);
                    n_head      = IDX_W'(r_fill);
                    n_hv        = 1'b1;
                    n_fill      = r_fill + CNT_W'(1);
                    if (r_fill == r_last) begin
                        n_state = S_RESP;
                    end
                end
            end
            S_POP: begin
                n_head = i_mem_rdata[IDX_W-1:0];
                n_hv   = i_mem_rdata[IDX_W];
                if (out_free) begin
                    n_ovalid = 1'b1;
                    n_ostat  = r_rstat;
                    n_ogrant = r_rgrant;
                    n_state  = S_IDLE;
                end else begin
                    n_state = S_RESP;
                end
            end
            S_RESP: begin
                if (out_free) begin
                    n_ovalid = 1'b1;
                    n_ostat  = r_rstat;
                    n_ogrant = r_rgrant;
                    n_state  = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    // control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_IDLE;
            r_hv     <= 1'b0;
            r_bump   <= '0;
            r_ovalid <= 1'b0;
            r_refill <= 1'b0;
        end else begin
            r_state  <= n_state;
            r_hv     <= n_hv;
            r_bump   <= n_bump;
            r_ovalid <= n_ovalid;
            r_refill <= n_refill;
        end
    end

    // payload registers
    always_ff @(posedge i_clk) begin
        r_head   <= n_head;
        r_fill   <= n_fill;
        r_last   <= n_last;
        r_rstat  <= n_rstat;
        r_rgrant <= n_rgrant;
        r_ostat  <= n_ostat;
        r_ogrant <= n_ogrant;
    end

endmodule

`default_nettype wire

FILE: bench/fixed_block_pool_allocator_tb.sv
// self-checking testbench for the fixed block pool allocator, with its own free-list predictor
`default_nettype none

module fixed_block_pool_allocator_tb
    import fbpa_pkg::*;
();

    localparam int POOL_LIMIT = 256;

    // one request and one reply as the testbench sees them
    typedef struct {
        logic [1:0]  cmd;
        logic [15:0] size;
        logic [7:0]  idx;
    } t_request;

    typedef struct {
        logic [1:0] status;
        logic [7:0] grant;
    } t_reply;

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        i_cfg_we = 1'b0;
    logic [1:0]  i_cfg_idx = '0;
    logic [8:0]  i_cfg_data = '0;
    logic        s_axis_tvalid = 1'b0;
    logic        s_axis_tready;
    logic [23:0] s_axis_tdata = '0;   // request_size[15:0], block_index[23:16]
    logic [1:0]  s_axis_tuser = '0;   // cmd[1:0]
    logic        m_axis_tvalid;
    logic        m_axis_tready = 1'b0;
    logic [15:0] m_axis_tdata;        // status[1:0], granted_block[9:2], zero[15:10]

    fixed_block_pool_allocator #(
        .NUM_BLOCKS(POOL_LIMIT)
    ) dut (
        .i_clk(i_clk),
        .i_rst_n(i_rst_n),
        .i_cfg_we(i_cfg_we),
        .i_cfg_idx(i_cfg_idx),
        .i_cfg_data(i_cfg_data),
        .s_axis_tvalid(s_axis_tvalid),
        .s_axis_tready(s_axis_tready),
        .s_axis_tdata(s_axis_tdata),
        .s_axis_tuser(s_axis_tuser),
        .m_axis_tvalid(m_axis_tvalid),
        .m_axis_tready(m_axis_tready),
        .m_axis_tdata(m_axis_tdata)
    );

    always #4 i_clk = ~i_clk;

    // predictor copy of the configuration and the free list
    logic [8:0] cfg_pool = 9'd256;
    logic       cfg_lazy = 1'b0;
    logic [8:0] cfg_batch = 9'd16;
    logic [8:0] link_next [POOL_LIMIT];
    bit         link_ok [POOL_LIMIT];
    logic [8:0] free_head = '0;
    bit         head_ok = 1'b0;
    logic [8:0] bump_ptr = '0;

    t_request   request_backlog [$];
    t_reply     predicted_replies [$];
    logic [7:0] held_blocks [$];      // blocks granted and not yet handed back
    t_request   cur_req;
    bit         calm = 1'b0;
    int         error_count = 0;
    int         holds_asked = 0;
    int         holds_done = 0;
    int         hold_left = 0;

    task automatic report_mismatch(input string what);
        if (error_count < 100)
            $display("MISMATCH at %0t: %s", $realtime, what);
        error_count++;
    endtask

    function automatic void push_free(input logic [8:0] blk);
        link_next[blk] = free_head;
        link_ok[blk] = head_ok;
        free_head = blk;
        head_ok = 1'b1;
    endfunction

    // reply of the allocator to one request, updating the predicted list
    function automatic t_reply serve_request(input t_request r);
        t_reply     o;
        logic [8:0] n;
        logic [8:0] amount;
        int         k;
        o.status = ST_OK;
        o.grant = '0;
        n = (cfg_pool > POOL_LIMIT) ? 9'(POOL_LIMIT) : cfg_pool;
        case (r.cmd)
            CMD_ALLOC: begin
                if (r.size == 16'd0) begin
                    o.status = ST_ZERO;
                end else begin
                    // lazy refill from the bump pointer when the list ran dry
                    if (!head_ok && cfg_lazy) begin
                        amount = (bump_ptr < n) ? n - bump_ptr : 9'd0;
                        if (cfg_batch < amount)
                            amount = cfg_batch;
                        for (k = 0; k < amount; k++) begin
                            push_free(bump_ptr);
                            bump_ptr++;
                        end
                    end
                    if (!head_ok) begin
                        o.status = ST_EMPTY;
                    end else begin
                        o.grant = free_head[7:0];
                        head_ok = link_ok[free_head];
                        free_head = link_next[free_head];
                        held_blocks.push_back(o.grant);
                    end
                end
            end
            CMD_FREE: begin
                if ({1'b0, r.idx} >= n) begin
                    o.status = ST_RANGE;
                end else begin
                    push_free({1'b0, r.idx});
                    for (k = 0; k < held_blocks.size(); k++) begin
                        if (held_blocks[k] == r.idx) begin
                            held_blocks.delete(k);
                            break;
                        end
                    end
                end
            end
            CMD_REBUILD: begin
                head_ok = 1'b0;
                free_head = '0;
                for (k = 0; k < n; k++)
                    push_free(9'(k));
                bump_ptr = n;
                held_blocks.delete();
            end
            default: ;
        endcase
        return o;
    endfunction

    // request driver: predicts each transaction as it is accepted
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            s_axis_tvalid <= 1'b0;
        end else begin
            if (s_axis_tvalid && s_axis_tready)
                predicted_replies.push_back(serve_request(cur_req));
            if (!s_axis_tvalid || s_axis_tready) begin
                if (request_backlog.size() != 0 && (calm || $urandom_range(99) >= 11)) begin
                    cur_req = request_backlog.pop_front();
                    s_axis_tvalid <= 1'b1;
                    s_axis_tdata <= {cur_req.idx, cur_req.size};
                    s_axis_tuser <= cur_req.cmd;
                end else begin
                    s_axis_tvalid <= 1'b0;
                end
            end
        end
    end

    // reply monitor with random back-pressure and requested long hold-offs
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            m_axis_tready <= 1'b0;
        end else begin
            if (m_axis_tvalid && m_axis_tready) begin
                if (predicted_replies.size() == 0) begin
                    report_mismatch($sformatf("reply %h with no request outstanding",
                                              m_axis_tdata));
                end else begin
                    t_reply want;
                    want = predicted_replies.pop_front();
                    if (m_axis_tdata[1:0] !== want.status)
                        report_mismatch($sformatf("status %0d, wanted %0d",
                                                  m_axis_tdata[1:0], want.status));
                    if (m_axis_tdata[9:2] !== want.grant)
                        report_mismatch($sformatf("granted block %0d, wanted %0d",
                                                  m_axis_tdata[9:2], want.grant));
                end
            end
            if (hold_left != 0) begin
                hold_left <= hold_left - 1;
                m_axis_tready <= 1'b0;
            end else if (holds_asked != holds_done) begin
                hold_left <= 400;
                holds_done <= holds_done + 1;
                m_axis_tready <= 1'b0;
            end else begin
                m_axis_tready <= calm || ($urandom_range(99) >= 11);
            end
        end
    end

    task automatic queue_request(input logic [1:0] cmd, input logic [15:0] size,
                                 input logic [7:0] idx);
        t_request r;
        r.cmd = cmd;
        r.size = size;
        r.idx = idx;
        request_backlog.push_back(r);
    endtask

    task automatic wait_drained();
        do
            @(negedge i_clk);
        while (request_backlog.size() != 0 || s_axis_tvalid || predicted_replies.size() != 0);
    endtask

    task automatic write_cfg(input logic [1:0] idx, input logic [8:0] val);
        @(posedge i_clk);
        i_cfg_we <= 1'b1;
        i_cfg_idx <= idx;
        i_cfg_data <= val;
        case (idx)
            CFG_POOL_BLOCKS:  cfg_pool = val;
            CFG_LAZY_MODE:    cfg_lazy = val[0];
            CFG_REFILL_BATCH: cfg_batch = val;
            default: ;
        endcase
    endtask

    // all three registers, written while the block is idle
    task automatic set_config(input logic [8:0] pool, input logic lazy, input logic [8:0] batch);
        write_cfg(CFG_POOL_BLOCKS, pool);
        write_cfg(CFG_LAZY_MODE, {8'd0, lazy});
        write_cfg(CFG_REFILL_BATCH, batch);
        @(posedge i_clk);
        i_cfg_we <= 1'b0;
    endtask

    // random traffic mostly made of allocs and frees of blocks still held
    task automatic run_phase(input logic [8:0] pool, input logic lazy, input logic [8:0] batch,
                             input int count, input bit quiet, input bit squeeze);
        logic [7:0] spare [$];
        t_request   r;
        int         made;
        int         chunk;
        int         roll;
        int         j;
        int         k;
        set_config(pool, lazy, batch);
        calm = quiet;
        made = 0;
        while (made < count) begin
            chunk = (squeeze && made == 0) ? 40 : $urandom_range(8, 30);
            if (chunk > count - made)
                chunk = count - made;
            if (squeeze && made == 0)
                holds_asked++;
            spare = held_blocks;
            for (k = 0; k < chunk; k++) begin
                roll = $urandom_range(99);
                r.cmd = CMD_ALLOC;
                r.size = 16'($urandom_range(1, 65535));
                r.idx = 8'($urandom);
                if (roll < 30) begin
                    if (spare.size() != 0) begin
                        j = $urandom_range(spare.size() - 1);
                        r.cmd = CMD_FREE;
                        r.idx = spare[j];
                        spare.delete(j);
                    end
                end else if (roll < 36) begin
                    r.size = '0;
                end else if (roll < 42) begin
                    r.cmd = CMD_FREE;
                    if ($urandom_range(1))
                        r.idx = 8'($urandom_range(0, (pool > 255) ? 255 : pool));
                end else if (roll == 42 || (roll == 43 && pool <= 64)) begin
                    r.cmd = CMD_REBUILD;
                end else if (roll < 46) begin
                    r.cmd = CMD_RSVD;
                end else if (roll < 50) begin
                    r.size = $urandom_range(1) ? 16'hFFFF : 16'd1;
                end
                // a plain list needs a rebuild before it grants anything
                if (made == 0 && k == 0 && !lazy)
                    r.cmd = CMD_REBUILD;
                request_backlog.push_back(r);
            end
            made += chunk;
            wait_drained();
        end
        calm = 1'b0;
    endtask

    // stimulus and end of run
    initial begin
        repeat (5) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // list empty after reset, zero size, unknown command, single pushes
        queue_request(CMD_ALLOC, 16'd5, 8'h5A);
        queue_request(CMD_ALLOC, 16'd0, 8'h00);
        queue_request(CMD_RSVD, 16'hFFFF, 8'hFF);
        queue_request(CMD_FREE, 16'hFFFF, 8'd255);
        queue_request(CMD_ALLOC, 16'hFFFF, 8'h00);
        queue_request(CMD_ALLOC, 16'd1, 8'hA5);
        queue_request(CMD_FREE, 16'd0, 8'd0);
        queue_request(CMD_FREE, 16'd0, 8'd0);
        queue_request(CMD_ALLOC, 16'h8000, 8'h00);
        queue_request(CMD_ALLOC, 16'd1, 8'h00);
        queue_request(CMD_ALLOC, 16'd1, 8'h00);
        wait_drained();

        // lazy mode with the list still holding block 0 from the double free, then range and rebuild
        set_config(9'd4, 1'b1, 9'd3);
        queue_request(CMD_ALLOC, 16'd1, 8'h00);
        queue_request(CMD_ALLOC, 16'd2, 8'h00);
        queue_request(CMD_ALLOC, 16'd3, 8'h00);
        queue_request(CMD_ALLOC, 16'd4, 8'h00);
        queue_request(CMD_ALLOC, 16'd5, 8'h00);
        queue_request(CMD_FREE, 16'd0, 8'd4);
        queue_request(CMD_FREE, 16'd0, 8'd255);
        queue_request(CMD_FREE, 16'd0, 8'd3);
        queue_request(CMD_ALLOC, 16'd0, 8'hFF);
        queue_request(CMD_ALLOC, 16'h7FFF, 8'h00);
        queue_request(CMD_REBUILD, 16'd0, 8'h00);
        queue_request(CMD_ALLOC, 16'd9, 8'h00);
        queue_request(CMD_RSVD, 16'd0, 8'h00);
        wait_drained();

        run_phase(9'd256, 1'b0, 9'd16, 250, 1'b1, 1'b0);
        run_phase(9'd8, 1'b1, 9'd3, 250, 1'b0, 1'b0);
        run_phase(9'd1, 1'b1, 9'd1, 150, 1'b0, 1'b0);
        run_phase(9'd256, 1'b1, 9'd256, 250, 1'b0, 1'b1);
        run_phase(9'd37, 1'b0, 9'd256, 250, 1'b0, 1'b0);
        run_phase(9'd256, 1'b1, 9'd1, 250, 1'b0, 1'b0);
        run_phase(9'd16, 1'b0, 9'd1, 250, 1'b0, 1'b0);

        // room for a stray reply after the longest rebuild
        repeat (300) @(negedge i_clk);
        if (error_count == 0 && predicted_replies.size() == 0) begin
            $display("fixed_block_pool_allocator verification clean");
        end else begin
            $display("fixed_block_pool_allocator verification failed");
        end
        $finish;
    end

    // hang guard
    initial begin
        #40000000;
        $display("fixed_block_pool_allocator verification failed");
        $finish;
    end

endmodule

`default_nettype wire
